// File: hdl/u8c_pkg.sv
// u8c_pkg: shared types and constants of the utf8_codec block
// used by u8c_core and utf8_codec; depends on nothing else
`default_nettype none

package u8c_pkg;

  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  localparam logic [30:0] ERR_VALUE = 31'h7F;

  typedef struct packed {
    logic [31:0] data_value;
    logic        end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [30:0] out_value;
    logic        invalid;
    logic        last_of_run;
    logic [2:0]  run_length;
  } out_item_t;

  // decoder sequence state
  typedef struct packed {
    logic [2:0]  bytes_pending;
    logic [30:0] code_accumulator;
    logic [2:0]  sequence_length;
  } seq_t;

  // what one processing step reports back to the control logic
  typedef struct packed {
    logic emit;
    logic done;
  } step_t;

endpackage

`default_nettype wire

// File: hdl/u8c_core.sv
// u8c_core: combinational datapath for one step of the codec
// decodes one byte against the sequence state, or forms one encoded byte
// depends on u8c_pkg
`default_nettype none

module u8c_core (
  input  wire logic            mode,
  input  wire u8c_pkg::in_item_t item,
  input  wire u8c_pkg::seq_t   seq,
  input  wire logic [2:0]      byte_idx,
  output u8c_pkg::seq_t        seq_nxt,
  output u8c_pkg::out_item_t   res,
  output u8c_pkg::step_t       ctl
);
  import u8c_pkg::*;

  logic [31:0] ch;
  logic [7:0]  b;
  logic [2:0]  enc_len;
  logic [7:0]  lead;
  logic [2:0]  tail_k;
  logic [5:0]  tail_bits;
  logic [7:0]  enc_byte;
  logic        enc_last;
  logic [2:0]  cont;
  logic [4:0]  payload;
  logic        lead_ok;
  logic [30:0] acc_nxt;
  logic [2:0]  pend_nxt;

  assign ch = item.data_value;
  assign b  = item.data_value[7:0];

  // encoder: run length and leading byte
  always_comb begin
    if (ch >= 32'h0400_0000) begin
      enc_len = 3'd6;
      lead    = {6'b111111, ch[31:30]};
    end else if (ch >= 32'h0020_0000) begin
      enc_len = 3'd5;
      lead    = {6'b111110, ch[25:24]};
    end else if (ch >= 32'h0001_0000) begin
      enc_len = 3'd4;
      lead    = {5'b11110, ch[20:18]};
    end else if (ch >= 32'h0000_0800) begin
      enc_len = 3'd3;
      lead    = {4'b1110, ch[15:12]};
    end else if (ch >= 32'h0000_0080) begin
      enc_len = 3'd2;
      lead    = {3'b110, ch[10:6]};
    end else begin
      enc_len = 3'd1;
      lead    = ch[7:0];
    end
  end

  // six-bit group for a continuation byte, counted from the low end
  assign tail_k = enc_len - 3'd1 - byte_idx;

  always_comb begin
    case (tail_k)
      3'd0:    tail_bits = ch[5:0];
      3'd1:    tail_bits = ch[11:6];
      3'd2:    tail_bits = ch[17:12];
      3'd3:    tail_bits = ch[23:18];
      3'd4:    tail_bits = ch[29:24];
      default: tail_bits = ch[5:0];
    endcase
  end

  assign enc_byte = (byte_idx == 3'd0) ? lead : {2'b10, tail_bits};
  assign enc_last = (byte_idx == enc_len - 3'd1);

  // decoder: leading byte class
  always_comb begin
    lead_ok = 1'b1;
    if ((b & 8'hFE) == 8'hFC) begin
      cont = 3'd5; payload = {4'd0, b[0]};
    end else if ((b & 8'hFC) == 8'hF8) begin
      cont = 3'd4; payload = {3'd0, b[1:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      cont = 3'd3; payload = {2'd0, b[2:0]};
    end else if ((b & 8'hF0) == 8'hE0) begin
      cont = 3'd2; payload = {1'b0, b[3:0]};
    end else if ((b & 8'hE0) == 8'hC0) begin
      cont = 3'd1; payload = b[4:0];
    end else begin
      cont = 3'd0; payload = 5'd0; lead_ok = 1'b0;
    end
  end

  // continuation marker is not checked
  assign acc_nxt  = {seq.code_accumulator[24:0], b[5:0]};
  assign pend_nxt = seq.bytes_pending - 3'd1;

  always_comb begin
    seq_nxt  = seq;
    res      = '0;
    ctl.emit = 1'b0;
    ctl.done = 1'b1;
    if (mode == MODE_ENCODE) begin
      ctl.emit        = 1'b1;
      ctl.done        = enc_last;
      res.out_value   = {23'd0, enc_byte};
      res.last_of_run = enc_last;
      res.run_length  = enc_len;
    end else begin
      res.last_of_run = 1'b1;
      if (seq.bytes_pending == 3'd0) begin
        if (!b[7]) begin
          ctl.emit       = 1'b1;
          res.out_value  = {23'd0, b};
          res.run_length = 3'd1;
        end else if (!lead_ok || item.end_of_buffer) begin
          ctl.emit       = 1'b1;
          res.out_value  = ERR_VALUE;
          res.invalid    = 1'b1;
          res.run_length = 3'd1;
        end else begin
          seq_nxt.bytes_pending    = cont;
          seq_nxt.code_accumulator = {26'd0, payload};
          seq_nxt.sequence_length  = cont + 3'd1;
        end
      end else begin
        seq_nxt.bytes_pending    = pend_nxt;
        seq_nxt.code_accumulator = acc_nxt;
        if (pend_nxt == 3'd0) begin
          ctl.emit       = 1'b1;
          res.out_value  = acc_nxt;
          res.run_length = seq.sequence_length;
          seq_nxt        = '0;
        end else if (item.end_of_buffer) begin
          // truncated sequence
          ctl.emit       = 1'b1;
          res.out_value  = ERR_VALUE;
          res.invalid    = 1'b1;
          res.run_length = seq.sequence_length - pend_nxt;
          seq_nxt        = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/utf8_codec.sv
// utf8_codec: six-byte UTF-8 decoder/encoder, top level
// a result is registered in out_data_r after its item is registered in item_r
// decode: one byte per cycle unless stalled; encode: 1..6 output bytes per code point,
// formed in turn; the single output register takes one byte a cycle unless stalled
// reset: synchronous, mode returns to decode and the sequence state to idle
`default_nettype none

module utf8_codec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire u8c_pkg::in_item_t   in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      u8c_pkg::out_item_t  out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);
  import u8c_pkg::*;

  logic      mode_r;
  seq_t      seq_r;
  seq_t      seq_nxt;
  logic      item_v_r;
  in_item_t  item_r;
  logic [2:0] idx_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t res;
  step_t     ctl;
  logic      adv;
  logic      step;
  logic      item_free;
  logic      accept;

  u8c_core u_core (
    .mode     (mode_r),
    .item     (item_r),
    .seq      (seq_r),
    .byte_idx (idx_r),
    .seq_nxt  (seq_nxt),
    .res      (res),
    .ctl      (ctl)
  );

  assign adv       = !out_valid_r || !out_stall;
  assign step      = item_v_r && adv;
  assign item_free = !item_v_r || (step && ctl.done);
  assign accept    = in_valid && item_free;
  assign in_stall  = !item_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DECODE;
      seq_r       <= '0;
      item_v_r    <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
        seq_r  <= '0;
      end else if (step) begin
        seq_r <= seq_nxt;
      end
      if (step) begin
        idx_r <= ctl.done ? 3'd0 : idx_r + 3'd1;
      end
      if (accept) begin
        item_v_r <= 1'b1;
      end else if (step && ctl.done) begin
        item_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= step && ctl.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (step && ctl.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // byte index stays inside a six-byte run
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd6 && idx_r != 3'd7)
    else $error("encode byte index out of range");

  // decode never walks the byte index
  a_idx_decode: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DECODE |-> idx_r == 3'd0)
    else $error("byte index moved in decode mode");

  // at most five continuation bytes pending
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.bytes_pending != 3'd6 && seq_r.bytes_pending != 3'd7)
    else $error("too many pending continuation bytes");

  // an error result always carries the substitute value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.invalid |-> out_data_r.out_value == ERR_VALUE)
    else $error("error item without substitute value");

  // every encode step leaves a valid, unflagged byte in the output register
  a_enc_noerr: assert property (@(posedge clk) disable iff (!rst_n)
    step && ctl.emit && mode_r == MODE_ENCODE |=> out_valid_r && !out_data_r.invalid)
    else $error("encode item lost or flagged invalid");

endmodule

`default_nettype wire

// File: tb/utf8_codec_tb.sv
// utf8_codec_tb: self-checking bench for the six-byte utf8_codec, decode and encode modes
// directed rows first, then random byte streams and code points checked against a predictor
// depends on u8c_pkg and utf8_codec
`default_nettype none

module utf8_codec_tb;
  import u8c_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 120;
  localparam int PHASE_ITEMS   = 22;

  localparam logic [31:0] ENC2_MIN = 32'h80;
  localparam logic [31:0] ENC3_MIN = 32'h800;
  localparam logic [31:0] ENC4_MIN = 32'h10000;
  localparam logic [31:0] ENC5_MIN = 32'h200000;
  localparam logic [31:0] ENC6_MIN = 32'h4000000;

  localparam out_item_t BAD_BYTE = '{ERR_VALUE, 1'b1, 1'b1, 3'd1};
  localparam out_item_t NUL_ONE  = '{31'h0, 1'b0, 1'b1, 3'd1};
  localparam out_item_t DEL_ONE  = '{31'h7F, 1'b0, 1'b1, 3'd1};

  typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_MODE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] data;
    logic        eob;
    out_item_t   want;
  } stim_row_t;

  stim_row_t directed_rows [0:25] = '{
    '{ROW_PINNED, 32'h00,       1'b0, NUL_ONE},
    '{ROW_PINNED, 32'h7F,       1'b0, DEL_ONE},
    '{ROW_PINNED, 32'h80,       1'b0, BAD_BYTE},   // stray continuation
    '{ROW_PINNED, 32'hBF,       1'b0, BAD_BYTE},
    '{ROW_PINNED, 32'hFE,       1'b0, BAD_BYTE},
    '{ROW_PINNED, 32'hFFFFFFFF, 1'b1, BAD_BYTE},   // upper bits ignored
    '{ROW_ITEM,   32'hC3,       1'b0, '0},
    '{ROW_ITEM,   32'hA9,       1'b0, '0},
    '{ROW_ITEM,   32'hFD,       1'b0, '0},         // six-byte max code point
    '{ROW_ITEM,   32'hBF,       1'b0, '0},
    '{ROW_ITEM,   32'hBF,       1'b0, '0},
    '{ROW_ITEM,   32'hBF,       1'b0, '0},
    '{ROW_ITEM,   32'hBF,       1'b0, '0},
    '{ROW_ITEM,   32'hBF,       1'b0, '0},
    '{ROW_PINNED, 32'hE2,       1'b1, BAD_BYTE},   // end of buffer on a leading byte
    '{ROW_ITEM,   32'hF0,       1'b0, '0},
    '{ROW_ITEM,   32'h90,       1'b1, '0},         // truncated after two bytes
    '{ROW_ITEM,   32'hE2,       1'b0, '0},         // left pending, dropped by the mode write
    '{ROW_MODE,   32'h1,        1'b0, '0},
    '{ROW_PINNED, 32'h0,        1'b0, NUL_ONE},
    '{ROW_ITEM,   32'h7FFFFFFF, 1'b0, '0},
    '{ROW_ITEM,   32'hFFFFFFFF, 1'b1, '0},
    '{ROW_ITEM,   32'h80000000, 1'b0, '0},
    '{ROW_ITEM,   32'h800,      1'b0, '0},
    '{ROW_MODE,   32'h0,        1'b0, '0},
    '{ROW_ITEM,   32'h41,       1'b1, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // predictor state
  logic        cur_mode = MODE_DECODE;
  logic [2:0]  dec_pending = '0;
  logic [2:0]  dec_len = '0;
  logic [30:0] dec_acc = '0;

  out_item_t   codec_results_due[$];
  out_item_t   pinned[int];
  out_item_t   head;
  int          accepted_cnt = 0;
  int          sent_cnt = 0;
  int          burst_left = 0;
  int          results_seen = 0;
  int          bad_seen = 0;
  int          mode_writes = 0;
  int          fails = 0;
  int unsigned cycle_cnt = 0;

  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int unsigned rx_cycle = 0;

  utf8_codec dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_item_t mk_result(logic [30:0] value, logic bad, logic last,
                                          logic [2:0] len);
    out_item_t r;
    r.out_value   = value;
    r.invalid     = bad;
    r.last_of_run = last;
    r.run_length  = len;
    return r;
  endfunction

  function automatic void clear_sequence();
    dec_pending = '0;
    dec_acc     = '0;
    dec_len     = '0;
  endfunction

  // works out the results of one accepted item and queues them
  function automatic void predict_codec(in_item_t it, int idx);
    out_item_t   r[$];
    logic [7:0]  b;
    logic [7:0]  lead;
    logic [2:0]  cont;
    logic [30:0] payload;
    logic [31:0] ch;
    int          n;
    int          i;
    b  = it.data_value[7:0];
    ch = it.data_value;
    if (cur_mode == MODE_DECODE) begin
      if (dec_pending == 0) begin
        if (!b[7]) begin
          r = {r, mk_result({23'd0, b}, 1'b0, 1'b1, 3'd1)};
        end else begin
          casez (b)
            8'b1111110?: begin cont = 3'd5; payload = 31'(b[0]);   end
            8'b111110??: begin cont = 3'd4; payload = 31'(b[1:0]); end
            8'b11110???: begin cont = 3'd3; payload = 31'(b[2:0]); end
            8'b1110????: begin cont = 3'd2; payload = 31'(b[3:0]); end
            8'b110?????: begin cont = 3'd1; payload = 31'(b[4:0]); end
            default:     begin cont = 3'd0; payload = '0;          end
          endcase
          if (cont == 0 || it.end_of_buffer) begin
            r = {r, mk_result(ERR_VALUE, 1'b1, 1'b1, 3'd1)};
          end else begin
            dec_pending = cont;
            dec_acc     = payload;
            dec_len     = cont + 3'd1;
          end
        end
      end else begin
        dec_acc     = {dec_acc[24:0], b[5:0]};
        dec_pending = dec_pending - 3'd1;
        if (dec_pending == 0) begin
          r = {r, mk_result(dec_acc, 1'b0, 1'b1, dec_len)};
          clear_sequence();
        end else if (it.end_of_buffer) begin
          r = {r, mk_result(ERR_VALUE, 1'b1, 1'b1, dec_len - dec_pending)};
          clear_sequence();
        end
      end
    end else begin
      if (ch >= ENC6_MIN)      begin n = 6; lead = 8'(ch >> 30) | 8'hFC; end
      else if (ch >= ENC5_MIN) begin n = 5; lead = 8'(ch >> 24) | 8'hF8; end
      else if (ch >= ENC4_MIN) begin n = 4; lead = 8'(ch >> 18) | 8'hF0; end
      else if (ch >= ENC3_MIN) begin n = 3; lead = 8'(ch >> 12) | 8'hE0; end
      else if (ch >= ENC2_MIN) begin n = 2; lead = 8'(ch >> 6)  | 8'hC0; end
      else                     begin n = 1; lead = ch[7:0];              end
      r = {r, mk_result({23'd0, lead}, 1'b0, n == 1, 3'(n))};
      for (i = 1; i < n; i++) begin
        r = {r, mk_result({23'd0, 2'b10, 6'(ch >> (6 * (n - 1 - i)))}, 1'b0,
                          i == n - 1, 3'(n))};
      end
    end
    if (pinned.exists(idx) && r.size() != 0) r[0] = pinned[idx];
    codec_results_due = {codec_results_due, r};
  endfunction

  // predictor, scoreboard and cycle count, all sampled at the rising edge
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      cur_mode = MODE_DECODE;
      clear_sequence();
    end else begin
      if (cfg_we) begin
        cur_mode = cfg_wdata;
        clear_sequence();
        mode_writes++;
      end
      if (in_valid && !in_stall) begin
        predict_codec(in_data, accepted_cnt);
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (codec_results_due.size() == 0) begin
          $error("result with nothing awaited: %h", out_data);
          fails++;
        end else begin
          head = codec_results_due.pop_front();
          results_seen++;
          if (out_data.invalid) bad_seen++;
          if (out_data.out_value !== head.out_value) begin
            $error("out_value: expected %h, got %h", head.out_value, out_data.out_value);
            fails++;
          end
          if (out_data.invalid !== head.invalid) begin
            $error("invalid: expected %b, got %b", head.invalid, out_data.invalid);
            fails++;
          end
          if (out_data.last_of_run !== head.last_of_run) begin
            $error("last_of_run: expected %b, got %b", head.last_of_run,
                   out_data.last_of_run);
            fails++;
          end
          if (out_data.run_length !== head.run_length) begin
            $error("run_length: expected %0d, got %0d", head.run_length,
                   out_data.run_length);
            fails++;
          end
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise a stall pattern chosen by rx_cycle[8:7]
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      rx_cycle  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_cycle[8:7])
          2'd0:    out_stall <= 1'b0;
          2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
          2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= rx_cycle[2];
        endcase
      end
    end
  end

  initial begin
    do @(posedge clk); while (cycle_cnt < CYCLE_LIMIT);
    $display("utf8_codec_tb failed");
    $finish;
  end

  // offers one item, in bursts with random gaps in between
  task automatic send_item(logic [31:0] value, logic eob);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= {value, eob};
    do @(posedge clk); while (in_stall);
    burst_left--;
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (codec_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed sequences with random payloads, some noise and truncation
  task automatic run_decode(int n_items);
    int          count;
    int          len;
    int          j;
    logic [31:0] w;
    logic        eob;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item($urandom, $urandom_range(0, 9) == 0);
        count++;
      end else begin
        len = $urandom_range(1, 6);
        w   = $urandom;
        case (len)
          1:       w[7]   = 1'b0;
          2:       w[7:5] = 3'b110;
          3:       w[7:4] = 4'b1110;
          4:       w[7:3] = 5'b11110;
          5:       w[7:2] = 6'b111110;
          default: w[7:1] = 7'b1111110;
        endcase
        for (j = 0; j < len; j++) begin
          if (j != 0) begin
            w = $urandom;
            if ($urandom_range(0, 9) != 0) w[7:6] = 2'b10;
          end
          if (j == len - 1) eob = ($urandom_range(0, 3) == 0);
          else              eob = ($urandom_range(0, 15) == 0);
          send_item(w, eob);
          count++;
          if (eob) break;
        end
      end
    end
  endtask

  task automatic run_encode(int n_items);
    int          k;
    logic [31:0] ch;
    for (k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 6))
        0:       ch = $urandom;
        1:       ch = $urandom_range(0, ENC2_MIN - 1);
        2:       ch = $urandom_range(ENC2_MIN, ENC3_MIN - 1);
        3:       ch = $urandom_range(ENC3_MIN, ENC4_MIN - 1);
        4:       ch = $urandom_range(ENC4_MIN, ENC5_MIN - 1);
        5:       ch = $urandom_range(ENC5_MIN, ENC6_MIN - 1);
        default: ch = $urandom_range(ENC6_MIN, 32'h7FFFFFFF);
      endcase
      send_item(ch, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_MODE: write_mode(directed_rows[i].data[0]);
        ROW_PINNED: begin
          pinned[sent_cnt] = directed_rows[i].want;
          send_item(directed_rows[i].data, directed_rows[i].eob);
        end
        default: send_item(directed_rows[i].data, directed_rows[i].eob);
      endcase
    end
    for (phase = 0; phase < 5; phase++) begin
      write_mode(phase[0] ? MODE_ENCODE : MODE_DECODE);
      if (phase == 1) hold_req <= ~hold_req;  // receiver blocks while encode runs pile up
      if (phase == 3) begin
        run_encode(PHASE_ITEMS / 2);
        wait_drained();
        run_encode(PHASE_ITEMS / 2);
      end else if (phase[0]) begin
        run_encode(PHASE_ITEMS);
      end else begin
        run_decode(PHASE_ITEMS);
      end
    end
    wait_drained();
    $display("sent %0d items over %0d mode writes, checked %0d results (%0d flagged invalid)",
             sent_cnt, mode_writes, results_seen, bad_seen);
    $display("both modes ran under bursty input, shifting output stalls and one long hold-off");
    if (fails == 0 && codec_results_due.size() == 0) begin
      $display("utf8_codec_tb passed");
    end else begin
      $display("utf8_codec_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
